### rtl/arom_pkg.sv
// Shared types and sizing constants for the address range overlap merge block.
// Used by address_range_overlap_merge and arom_merge_step; depends on nothing.
package arom_pkg;

	// Store depth and the index and count widths that follow from it.
	localparam int CAPACITY = 32;
	localparam int IW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);

	// Fixed field widths.
	localparam int ADDR_W = 16;
	localparam int END_W  = 17;
	localparam int IDX_W  = 5;

	// One command word: a single address range.
	typedef struct packed {
		logic [ADDR_W-1:0] start_addr;
		logic [END_W-1:0]  end_addr;
		logic              last;
	} range_in_t;

	// One result word.
	typedef struct packed {
		logic [IDX_W-1:0]  entry_index;
		logic              kept;
		logic [ADDR_W-1:0] new_start;
		logic [END_W-1:0]  new_end;
		logic              overflow;
		logic              end_of_set;
	} result_t;

	// A range as held in the stores.
	typedef struct packed {
		logic [ADDR_W-1:0] s;
		logic [END_W-1:0]  e;
	} span_t;

	// Load-order store entry: the range and its position after sorting.
	typedef struct packed {
		span_t           span;
		logic [IW-1:0]   rank;
	} load_entry_t;

	// Sorted store entry: the range and its survival flag.
	typedef struct packed {
		span_t span;
		logic  kept;
	} sort_entry_t;

	// Outcome of merging one adjacent pair of sorted ranges.
	typedef struct packed {
		span_t cur;
		span_t nxt;
		logic  kept;
	} merge_res_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RK_KEY,
		ST_RK_SCAN,
		ST_RK_WRITE,
		ST_MG_FIRST,
		ST_MG_WALK,
		ST_MG_LAST,
		ST_EMIT
	} state_t;

endpackage

### rtl/address_range_overlap_merge.sv
// Top level of the address range overlap merge block: sequencer and both stores.
// Depends on arom_pkg and arom_merge_step.
//
// Usage: a command word (one range) is taken at a clock edge where start is high
// and busy is low. While collecting a set, busy stays low and one range loads per
// cycle. Ranges beyond the store depth are dropped and the set is flagged as
// overflowed. The word marked last ends the set; busy rises and the block works
// on the n stored ranges:
//   rank pass : one full scan of the load store per range (single read port) to find
//               each range's stable sorted position;
//   merge walk: one adjacent pair per cycle through the sorted store;
//   emit      : one result word per cycle in load order.
// Each result sits on the result port for one cycle, marked by result_strobe; the
// receiver cannot stall it.
// After reset the set is empty, no overflow is flagged and the block is idle.
// The stores need no clearing: only entries written in the current set are read.
module address_range_overlap_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  arom_pkg::range_in_t range_cmd,
	output logic                result_strobe,
	output arom_pkg::result_t   result
);
	import arom_pkg::*;

	// Stores: load order (with rank) and sorted order (with kept flag).
	load_entry_t load_mem [CAPACITY];
	sort_entry_t sort_mem [CAPACITY];

	state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [IW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [IW-1:0] rank_q;
	span_t         key_q;
	span_t         cur_q;

	logic          key_ld_s1;
	logic          scan_vld_s1;
	logic [IW-1:0] scan_j_s1;
	logic          b_vld_s1;
	logic          b_first_s1;
	logic          out_vld_s1;
	logic [IW-1:0] out_idx_s1;
	logic          out_vld_s2;
	logic [IW-1:0] out_idx_s2;

	logic          la_we;
	logic [IW-1:0] la_waddr;
	load_entry_t   la_wdata;
	logic [IW-1:0] la_raddr;
	load_entry_t   la_rdata_q;

	logic          sb_we;
	logic [IW-1:0] sb_waddr;
	sort_entry_t   sb_wdata;
	logic [IW-1:0] sb_raddr;
	sort_entry_t   sb_rdata_q;

	merge_res_t    mres;
	logic          scan_less;
	logic          issue_more;
	logic          last_rank;

	// Pair merge on the carried range and the word just read from the sorted store.
	arom_merge_step u_merge (
		.cur (cur_q),
		.nxt (sb_rdata_q.span),
		.res (mres)
	);

	// Load-order store with a registered read.
	always_ff @(posedge clk) begin
		if (la_we) begin
			load_mem[la_waddr] <= la_wdata;
		end
		la_rdata_q <= load_mem[la_raddr];
	end

	// Sorted store with a registered read.
	always_ff @(posedge clk) begin
		if (sb_we) begin
			sort_mem[sb_waddr] <= sb_wdata;
		end
		sb_rdata_q <= sort_mem[sb_raddr];
	end

	// Shared conditions of the sequencer.
	assign issue_more = (j_q < cnt_q);
	assign last_rank  = (CW'(i_q) == (cnt_q - CW'(1)));
	assign scan_less  = (la_rdata_q.span.s < key_q.s) ||
		((la_rdata_q.span.s == key_q.s) && (scan_j_s1 < i_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (start && range_cmd.last) begin
					state_d = ST_RK_KEY;
				end
			end
			ST_RK_KEY: begin
				state_d = ST_RK_SCAN;
			end
			ST_RK_SCAN: begin
				if (!issue_more && !scan_vld_s1) begin
					state_d = ST_RK_WRITE;
				end
			end
			ST_RK_WRITE: begin
				state_d = last_rank ? ST_MG_FIRST : ST_RK_KEY;
			end
			ST_MG_FIRST: begin
				state_d = ST_MG_WALK;
			end
			ST_MG_WALK: begin
				if (!issue_more && !b_vld_s1) begin
					state_d = ST_MG_LAST;
				end
			end
			ST_MG_LAST: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!issue_more && !out_vld_s1 && !out_vld_s2) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Store addresses, write enables and busy.
	always_comb begin
		busy     = 1'b1;
		la_we    = 1'b0;
		la_waddr = cnt_q[IW-1:0];
		la_wdata = '{span: '{s: range_cmd.start_addr, e: range_cmd.end_addr}, rank: '0};
		la_raddr = i_q;
		sb_we    = 1'b0;
		sb_waddr = i_q;
		sb_wdata = '{span: cur_q, kept: 1'b1};
		sb_raddr = j_q[IW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				busy  = 1'b0;
				la_we = start && (cnt_q < CW'(CAPACITY));
			end
			ST_RK_KEY: begin
				la_raddr = i_q;
			end
			ST_RK_SCAN: begin
				la_raddr = j_q[IW-1:0];
			end
			ST_RK_WRITE: begin
				la_we    = 1'b1;
				la_waddr = i_q;
				la_wdata = '{span: key_q, rank: rank_q};
				sb_we    = 1'b1;
				sb_waddr = rank_q;
				sb_wdata = '{span: key_q, kept: 1'b1};
			end
			ST_MG_FIRST: begin
				sb_raddr = '0;
			end
			ST_MG_WALK: begin
				sb_we    = b_vld_s1 && !b_first_s1;
				sb_wdata = '{span: mres.cur, kept: mres.kept};
			end
			ST_MG_LAST: begin
				sb_we = 1'b1;
			end
			ST_EMIT: begin
				la_raddr = j_q[IW-1:0];
				sb_raddr = la_rdata_q.rank;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Sequencer state, counters and read tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			rank_q      <= '0;
			key_ld_s1   <= 1'b0;
			scan_vld_s1 <= 1'b0;
			b_vld_s1    <= 1'b0;
			b_first_s1  <= 1'b0;
			out_vld_s1  <= 1'b0;
			out_vld_s2  <= 1'b0;
		end else begin
			state_q     <= state_d;
			key_ld_s1   <= (state_q == ST_RK_KEY);
			scan_vld_s1 <= (state_q == ST_RK_SCAN) && issue_more;
			b_vld_s1    <= (state_q == ST_MG_FIRST) || ((state_q == ST_MG_WALK) && issue_more);
			b_first_s1  <= (state_q == ST_MG_FIRST);
			out_vld_s1  <= (state_q == ST_EMIT) && issue_more;
			out_vld_s2  <= out_vld_s1;
			case (state_q)
				ST_LOAD: begin
					if (start) begin
						if (cnt_q < CW'(CAPACITY)) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (range_cmd.last) begin
							i_q <= '0;
						end
					end
				end
				ST_RK_KEY: begin
					j_q    <= '0;
					rank_q <= '0;
				end
				ST_RK_SCAN: begin
					if (issue_more) begin
						j_q <= j_q + CW'(1);
					end
					if (scan_vld_s1 && scan_less) begin
						rank_q <= rank_q + IW'(1);
					end
				end
				ST_RK_WRITE: begin
					if (last_rank) begin
						i_q <= '0;
						j_q <= CW'(1);
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_MG_WALK: begin
					if (issue_more) begin
						j_q <= j_q + CW'(1);
					end
					if (b_vld_s1 && !b_first_s1) begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_MG_LAST: begin
					j_q <= '0;
				end
				ST_EMIT: begin
					if (issue_more) begin
						j_q <= j_q + CW'(1);
					end
					if (state_d == ST_LOAD) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
					j_q <= j_q;
				end
			endcase
		end
	end

	// Key latch, carried range and index tags travel without reset.
	always_ff @(posedge clk) begin
		if (key_ld_s1) begin
			key_q <= la_rdata_q.span;
		end
		if (b_vld_s1) begin
			cur_q <= b_first_s1 ? sb_rdata_q.span : mres.nxt;
		end
		scan_j_s1  <= j_q[IW-1:0];
		out_idx_s1 <= j_q[IW-1:0];
		out_idx_s2 <= out_idx_s1;
	end

	// Result word straight from the sorted store read register.
	assign result_strobe      = out_vld_s2;
	assign result.entry_index = IDX_W'(out_idx_s2);
	assign result.kept        = sb_rdata_q.kept;
	assign result.new_start   = sb_rdata_q.span.s;
	assign result.new_end     = sb_rdata_q.span.e;
	assign result.overflow    = ovf_q;
	assign result.end_of_set  = (CW'(out_idx_s2) == (cnt_q - CW'(1)));

endmodule

### rtl/arom_merge_step.sv
// Merge of one adjacent pair of ranges taken in sorted order.
// Depends on arom_pkg for the range and result types.
module arom_merge_step (
	input  arom_pkg::span_t    cur,
	input  arom_pkg::span_t    nxt,
	output arom_pkg::merge_res_t res
);
	import arom_pkg::*;

	logic [END_W-1:0] ce_eq;
	logic [END_W-1:0] ne_eq;
	logic [END_W-1:0] hi;
	logic [ADDR_W-1:0] lo;

	// Equal starts share the larger end first.
	always_comb begin
		ce_eq = cur.e;
		ne_eq = nxt.e;
		if (cur.s == nxt.s) begin
			if (cur.e > nxt.e) begin
				ne_eq = cur.e;
			end else begin
				ce_eq = nxt.e;
			end
		end
	end

	// An overlap gives both ranges the smaller start and the larger end.
	always_comb begin
		lo = (cur.s < nxt.s) ? cur.s : nxt.s;
		hi = (ce_eq > ne_eq) ? ce_eq : ne_eq;
		res.cur.s = cur.s;
		res.cur.e = ce_eq;
		res.nxt.s = nxt.s;
		res.nxt.e = ne_eq;
		if (ce_eq > {1'b0, nxt.s}) begin
			res.cur.s = lo;
			res.cur.e = hi;
			res.nxt.s = lo;
			res.nxt.e = hi;
		end
		// The first of a pair with the same final start is dropped.
		res.kept = (res.cur.s != res.nxt.s);
	end

endmodule
